>>> rtl/core/tile_scratchpad_bank_allocator_assert.svh
// assertion macros for the tile scratchpad bank allocator
// expects i_clk and i_rst_n in the scope of the module that includes it
`ifndef TILE_SCRATCHPAD_BANK_ALLOCATOR_ASSERT_SVH
`define TILE_SCRATCHPAD_BANK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, off while reset is held
`define TSBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define TSBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tsba_pkg.sv
// shared types and port widths for the tile scratchpad bank allocator
// no dependencies
package tsba_pkg;

    localparam int ID_PORT_W   = 16;
    localparam int SLOT_PORT_W = 3;
    localparam int BANK_PORT_W = 3;
    localparam int CNT_PORT_W  = 4;
    localparam int CFG_W       = 4;
    localparam int EPOCH_W     = 32;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    typedef enum logic [2:0] {
        ST_ISSUED  = 3'd0,
        ST_SKIPPED = 3'd1,
        ST_RETIRED = 3'd2,
        ST_FULL    = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    // table update for one beat
    typedef struct packed {
        logic issue;
        logic retire;
    } t_tbl_cmd;

endpackage

>>> rtl/core/tsba_table.sv
// live tile table: slot flags, ids and accumulator banks, with parallel lookups
// depends on tsba_pkg
module tsba_table #(
    parameter int MAX_BANKS = 8,
    parameter int ID_W      = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tsba_pkg::t_tbl_cmd            i_cmd,
    input  logic [((MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1)-1:0] i_ret_slot,
    input  logic                          i_accum,
    input  logic [ID_W-1:0]               i_layer,
    input  logic [ID_W-1:0]               i_fop,
    input  logic [((MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1)-1:0] i_bank,
    output logic [MAX_BANKS-1:0]          o_valid,
    output logic [$clog2(MAX_BANKS+1)-1:0] o_live,
    output logic                          o_hit,
    output logic [((MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1)-1:0] o_hit_bank,
    output logic [MAX_BANKS-1:0]          o_held,
    output logic [((MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1)-1:0] o_free_slot
);

    localparam int SW = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
    localparam int LW = $clog2(MAX_BANKS+1);

    logic [MAX_BANKS-1:0] r_valid;
    logic [MAX_BANKS-1:0] r_accum;
    logic [ID_W-1:0]      r_layer [MAX_BANKS];
    logic [ID_W-1:0]      r_fop   [MAX_BANKS];
    logic [SW-1:0]        r_bank  [MAX_BANKS];

    logic [SW-1:0] w_free;
    logic          w_free_found;

    always_comb begin
        w_free       = '0;
        w_free_found = 1'b0;
        o_hit        = 1'b0;
        o_hit_bank   = '0;
        o_live       = '0;
        for (int i = 0; i < MAX_BANKS; i++) begin
            if (!w_free_found && !r_valid[i]) begin
                w_free_found = 1'b1;
                w_free       = SW'(i);
            end
            if (!o_hit && r_valid[i] && r_accum[i] && r_layer[i] == i_layer &&
                r_fop[i] == i_fop) begin
                o_hit      = 1'b1;
                o_hit_bank = r_bank[i];
            end
            o_live = o_live + LW'(r_valid[i]);
        end
    end

    // bank b is held when any live slot points at it
    always_comb begin
        for (int b = 0; b < MAX_BANKS; b++) begin
            o_held[b] = 1'b0;
            for (int i = 0; i < MAX_BANKS; i++) begin
                if (r_valid[i] && r_bank[i] == SW'(b)) begin
                    o_held[b] = 1'b1;
                end
            end
        end
    end

    assign o_valid     = r_valid;
    assign o_free_slot = w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_cmd.issue) begin
                r_valid[w_free] <= 1'b1;
            end
            if (i_cmd.retire) begin
                r_valid[i_ret_slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_accum[w_free] <= i_accum;
            r_layer[w_free] <= i_layer;
            r_fop[w_free]   <= i_fop;
            r_bank[w_free]  <= i_bank;
        end
    end

endmodule

>>> rtl/core/tsba_bank.sv
// scratchpad bank rotation, accumulator bank pick and load epoch counter
// depends on tsba_pkg
module tsba_bank #(
    parameter int MAX_BANKS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_commit,
    input  logic [$clog2(MAX_BANKS+1)-1:0] i_depth,
    input  logic [MAX_BANKS-1:0]          i_held,
    input  logic                          i_hit,
    input  logic [((MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1)-1:0] i_hit_bank,
    output logic [((MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1)-1:0] o_spad,
    output logic [((MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1)-1:0] o_acc,
    output logic                          o_flush,
    output logic [tsba_pkg::EPOCH_W-1:0]  o_epoch
);

    localparam int SW = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
    localparam int DW = $clog2(MAX_BANKS+1);
    localparam int PW = 2*DW + 2;

    // x mod d for x up to MAX_BANKS: pick the one band k*d <= x < (k+1)*d
    function automatic logic [DW-1:0] mod_depth(input logic [DW:0] x,
                                                input logic [DW-1:0] d);
        logic [DW-1:0] r;
        logic [PW-1:0] lo;
        logic [PW-1:0] hi;
        r = '0;
        for (int k = 0; k <= MAX_BANKS; k++) begin
            lo = PW'(k) * PW'(d);
            hi = lo + PW'(d);
            if (PW'(x) >= lo && PW'(x) < hi) begin
                r = DW'(PW'(x) - lo);
            end
        end
        return r;
    endfunction

    logic [SW-1:0]              r_last_spad;
    logic [SW-1:0]              r_last_acc;
    logic [tsba_pkg::EPOCH_W-1:0] r_epoch;

    logic [SW-1:0] w_start;
    logic [SW-1:0] w_pick;
    logic          w_found;
    logic [DW:0]   w_pos;

    always_comb begin
        o_spad  = SW'(mod_depth((DW+1)'(r_last_spad) + (DW+1)'(1), i_depth));
        w_start = SW'(mod_depth((DW+1)'(r_last_acc) + (DW+1)'(1), i_depth));
        w_pick  = w_start;
        w_found = 1'b0;
        w_pos   = '0;
        // walk the ring from the bank after the last one taken
        for (int i = 0; i < MAX_BANKS; i++) begin
            w_pos = (DW+1)'(w_start) + (DW+1)'(i);
            if (w_pos >= (DW+1)'(i_depth)) begin
                w_pos = w_pos - (DW+1)'(i_depth);
            end
            if (!w_found && (DW+1)'(i) < (DW+1)'(i_depth) && !i_held[SW'(w_pos)]) begin
                w_found = 1'b1;
                w_pick  = SW'(w_pos);
            end
        end
        o_acc   = i_hit ? i_hit_bank : w_pick;
        o_flush = !i_hit;
    end

    assign o_epoch = r_epoch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_spad <= '0;
            r_last_acc  <= '0;
            r_epoch     <= tsba_pkg::EPOCH_W'(1);
        end else if (i_commit) begin
            r_last_spad <= o_spad;
            r_epoch     <= r_epoch + tsba_pkg::EPOCH_W'(1);
            if (!i_hit) begin
                r_last_acc <= w_pick;
            end
        end
    end

endmodule

>>> rtl/core/tile_scratchpad_bank_allocator.sv
// tile scratchpad bank allocator top level; depends on tsba_pkg, tsba_table, tsba_bank
// throughput: one beat per cycle while the result is not stalled; the slot table lookup
// and bank pick sit between the input register and the result register
// reset: synchronous active low; clears the slot valid flags, bank pointers,
// epoch counter (to 1), bank count register (to 2) and both registers' valids
`include "tile_scratchpad_bank_allocator_assert.svh"

module tile_scratchpad_bank_allocator #(
    parameter int MAX_BANKS = 8,
    parameter int ID_BITS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tsba_pkg::APB_AW-1:0]       paddr,
    input  logic [tsba_pkg::APB_DW-1:0]       pwdata,
    output logic [tsba_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_op,
    input  logic                              i_accum,
    input  logic [tsba_pkg::ID_PORT_W-1:0]    i_layer_id,
    input  logic [tsba_pkg::ID_PORT_W-1:0]    i_fused_op_id,
    input  logic                              i_skip,
    input  logic [tsba_pkg::SLOT_PORT_W-1:0]  i_slot,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [2:0]                        o_status,
    output logic [tsba_pkg::BANK_PORT_W-1:0]  o_spad_bank,
    output logic [tsba_pkg::BANK_PORT_W-1:0]  o_acc_bank,
    output logic                              o_acc_flush,
    output logic [tsba_pkg::SLOT_PORT_W-1:0]  o_given_slot,
    output logic [tsba_pkg::EPOCH_W-1:0]      o_tile_epoch,
    output logic [tsba_pkg::CNT_PORT_W-1:0]   o_live_count
);

    localparam int SW  = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
    localparam int DW  = $clog2(MAX_BANKS+1);
    localparam int IW  = (ID_BITS < tsba_pkg::ID_PORT_W) ? ID_BITS : tsba_pkg::ID_PORT_W;
    localparam int BPW = tsba_pkg::BANK_PORT_W;
    localparam int SPW = tsba_pkg::SLOT_PORT_W;
    localparam int CPW = tsba_pkg::CNT_PORT_W;
    localparam int CW  = tsba_pkg::CFG_W;
    localparam int AW  = tsba_pkg::APB_DW;
    localparam int EW  = tsba_pkg::EPOCH_W;

    // configuration register
    logic [CW-1:0] r_banks;
    logic          w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready && !paddr[2];
    assign prdata   = paddr[2] ? '0 : AW'(r_banks);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_banks <= CW'(2);
        end else if (w_cfg_we) begin
            r_banks <= pwdata[CW-1:0];
        end
    end

    logic [DW-1:0] w_depth;

    always_comb begin
        if (r_banks == '0) begin
            w_depth = DW'(1);
        end else if (32'(r_banks) > 32'(MAX_BANKS)) begin
            w_depth = DW'(MAX_BANKS);
        end else begin
            w_depth = DW'(r_banks);
        end
    end

    // input register
    logic            r_in_vld;
    logic            r_op;
    logic            r_accum;
    logic [IW-1:0]   r_layer;
    logic [IW-1:0]   r_fop;
    logic            r_skip;
    logic [SPW-1:0]  r_slot;
    logic            w_adv;
    logic            w_in_take;

    assign w_adv      = r_in_vld && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op    <= i_op;
            r_accum <= i_accum;
            r_layer <= i_layer_id[IW-1:0];
            r_fop   <= i_fused_op_id[IW-1:0];
            r_skip  <= i_skip;
            r_slot  <= i_slot;
        end
    end

    // table and bank logic
    tsba_pkg::t_tbl_cmd w_cmd;
    logic [MAX_BANKS-1:0] w_valid;
    logic [DW-1:0]        w_live;
    logic                 w_hit;
    logic [SW-1:0]        w_hit_bank;
    logic [MAX_BANKS-1:0] w_held;
    logic [SW-1:0]        w_free_slot;
    logic [SW-1:0]        w_spad;
    logic [SW-1:0]        w_acc;
    logic                 w_flush;
    logic [EW-1:0]        w_epoch;

    logic          w_in_range;
    logic [SW-1:0] w_slot_idx;
    logic          w_slot_ok;
    logic          w_full;
    logic          w_commit;
    logic          w_hit_use;

    assign w_in_range = 32'(r_slot) < 32'(MAX_BANKS);
    assign w_slot_idx = SW'(r_slot);
    assign w_slot_ok  = w_in_range && w_valid[w_slot_idx];
    assign w_full     = w_live >= w_depth;
    assign w_commit   = w_adv && !r_op && !w_full;
    assign w_hit_use  = r_accum && w_hit;
    assign w_cmd.issue  = w_commit && !r_skip;
    assign w_cmd.retire = w_adv && r_op && w_slot_ok;

    tsba_table #(
        .MAX_BANKS (MAX_BANKS),
        .ID_W      (IW)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_ret_slot  (w_slot_idx),
        .i_accum     (r_accum),
        .i_layer     (r_layer),
        .i_fop       (r_fop),
        .i_bank      (w_acc),
        .o_valid     (w_valid),
        .o_live      (w_live),
        .o_hit       (w_hit),
        .o_hit_bank  (w_hit_bank),
        .o_held      (w_held),
        .o_free_slot (w_free_slot)
    );

    tsba_bank #(
        .MAX_BANKS (MAX_BANKS)
    ) u_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_commit   (w_commit),
        .i_depth    (w_depth),
        .i_held     (w_held),
        .i_hit      (w_hit_use),
        .i_hit_bank (w_hit_bank),
        .o_spad     (w_spad),
        .o_acc      (w_acc),
        .o_flush    (w_flush),
        .o_epoch    (w_epoch)
    );

    // result for the beat in the input register
    tsba_pkg::t_status n_status;
    logic [BPW-1:0]    n_spad;
    logic [BPW-1:0]    n_acc;
    logic              n_flush;
    logic [SPW-1:0]    n_given;
    logic [EW-1:0]     n_epoch;
    logic [CPW-1:0]    n_live;

    always_comb begin
        n_spad  = '0;
        n_acc   = '0;
        n_flush = 1'b0;
        n_given = '0;
        n_epoch = '0;
        if (r_op) begin
            n_status = w_slot_ok ? tsba_pkg::ST_RETIRED : tsba_pkg::ST_EMPTY;
        end else if (w_full) begin
            n_status = tsba_pkg::ST_FULL;
        end else begin
            n_status = r_skip ? tsba_pkg::ST_SKIPPED : tsba_pkg::ST_ISSUED;
            n_spad   = BPW'(w_spad);
            n_acc    = BPW'(w_acc);
            n_flush  = w_flush;
            n_epoch  = w_epoch;
            if (!r_skip) begin
                n_given = SPW'(w_free_slot);
            end
        end
        n_live = CPW'((DW+1)'(w_live) + (DW+1)'(w_cmd.issue) - (DW+1)'(w_cmd.retire));
    end

    // result register
    tsba_pkg::t_status r_status;
    logic              r_out_vld;
    logic [BPW-1:0]    r_spad;
    logic [BPW-1:0]    r_acc;
    logic              r_flush;
    logic [SPW-1:0]    r_given;
    logic [EW-1:0]     r_epoch;
    logic [CPW-1:0]    r_live;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_status <= n_status;
            r_spad   <= n_spad;
            r_acc    <= n_acc;
            r_flush  <= n_flush;
            r_given  <= n_given;
            r_epoch  <= n_epoch;
            r_live   <= n_live;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_status     = r_status;
    assign o_spad_bank  = r_spad;
    assign o_acc_bank   = r_acc;
    assign o_acc_flush  = r_flush;
    assign o_given_slot = r_given;
    assign o_tile_epoch = r_epoch;
    assign o_live_count = r_live;

    // a stalled input beat only waits behind a stalled result beat
    `TSBA_ASSERT_NOW(a_stall_cause, o_in_stall,
        r_in_vld && r_out_vld && i_out_stall,
        "input stalled without a stalled result")
    // every beat that leaves the input register shows up as a result
    `TSBA_ASSERT_NEXT(a_adv_loads, w_adv, r_out_vld, "advanced beat produced no result")
    // the live count never exceeds the table size
    `TSBA_ASSERT_NOW(a_live_bound, r_out_vld, 32'(r_live) <= 32'(MAX_BANKS),
        "live count above table size")
    // retire and reject beats carry no bank or epoch
    `TSBA_ASSERT_NOW(a_idle_fields,
        r_out_vld && (r_status == tsba_pkg::ST_RETIRED || r_status == tsba_pkg::ST_FULL ||
        r_status == tsba_pkg::ST_EMPTY),
        !r_flush && r_epoch == '0 && r_given == '0,
        "non-issue beat carries allocation fields")

endmodule
